>>> src/cfb_pkg.sv
// Package: shared types, op codes and the CRC-16 fold function for the frame builder.
`timescale 1ns / 1ps
package cfb_pkg;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BODY  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // one queued unit of output work: one or two bytes
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       two;
      logic       done;
   } frame_entry_type;

   // MSB-first byte fold, unrolled into an XOR network
   function automatic logic [15:0] crc_fold8(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> src/cfb_req_if.sv
// Interface: input item channel of the frame builder.
`timescale 1ns / 1ps
interface cfb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] command;
   logic [7:0]  body_byte;

   modport source (output valid, output op, output command, output body_byte, input ready);
   modport sink (input valid, input op, input command, input body_byte, output ready);
endinterface

>>> src/cfb_rsp_if.sv
// Interface: result item channel of the frame builder.
`timescale 1ns / 1ps
interface cfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       frame_done;

   modport source (output valid, output out_byte, output last_of_run, output frame_done,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_run, input frame_done,
                 output ready);
endinterface

>>> src/cfb_front.sv
// Front end: accepts items, runs the CRC and queues the bytes to emit.
`timescale 1ns / 1ps
module cfb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [1:0]               in_op,
   input  logic [15:0]              in_command,
   input  logic [7:0]               in_body_byte,
   input  logic                     q_full,
   output logic                     push,
   output cfb_pkg::frame_entry_type push_entry
);
   import cfb_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      crc_in           = crc_ff;
      push             = 1'b0;
      push_entry.byte0 = in_body_byte;
      push_entry.byte1 = 8'h00;
      push_entry.two   = 1'b0;
      push_entry.done  = 1'b0;
      unique case (in_op)
         OP_START: begin
            push_entry.byte0 = in_command[7:0];
            push_entry.byte1 = in_command[15:8];
            push_entry.two   = 1'b1;
            push             = accept;
            if (accept) begin
               crc_in = crc_fold8(crc_fold8(CRC_INIT, in_command[7:0]), in_command[15:8]);
            end
         end
         OP_BODY: begin
            push = accept;
            if (accept) begin
               crc_in = crc_fold8(crc_ff, in_body_byte);
            end
         end
         OP_END: begin
            // CRC is sampled here, so later body bytes cannot disturb it
            push_entry.byte0 = crc_ff[7:0];
            push_entry.byte1 = crc_ff[15:8];
            push_entry.two   = 1'b1;
            push_entry.done  = 1'b1;
            push             = accept;
         end
         OP_NONE: begin
            push = 1'b0;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   ap_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("push while queue full");
   ap_crc_held_on_end: assert property (@(posedge clock) disable iff (reset)
      (accept && (in_op == OP_END || in_op == OP_NONE)) |=> crc_ff == $past(crc_ff))
      else $error("CRC changed on end or unused item");
   ap_start_pushes_two: assert property (@(posedge clock) disable iff (reset)
      (accept && in_op == OP_START) |-> (push && push_entry.two && !push_entry.done))
      else $error("start item not queued as two bytes");

endmodule

>>> src/cfb_queue.sv
// Short FIFO of pending output work between the front and back ends.
`timescale 1ns / 1ps
module cfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cfb_pkg::frame_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     head_valid,
   output cfb_pkg::frame_entry_type head_entry
);
   import cfb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   frame_entry_type slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == DEPTH_C);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("queue count overflow");
   ap_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   ap_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not follow push");

endmodule

>>> src/cfb_back.sv
// Back end: walks queued entries byte by byte into a registered output.
`timescale 1ns / 1ps
module cfb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  cfb_pkg::frame_entry_type head_entry,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [7:0]               out_byte,
   output logic                     out_last,
   output logic                     out_done
);
   import cfb_pkg::*;

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;   // first byte of a two-byte entry already sent
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       load;

   assign load      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_done  = done_ff;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (head_entry.two && !phase_ff) begin
               byte_in  = head_entry.byte0;
               last_in  = 1'b0;
               done_in  = 1'b0;
               phase_in = 1'b1;
            end else begin
               byte_in  = phase_ff ? head_entry.byte1 : head_entry.byte0;
               last_in  = 1'b1;
               done_in  = head_entry.done;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   ap_phase_has_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> head_valid)
      else $error("second byte pending with empty queue");
   ap_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> last_ff)
      else $error("frame end not on last byte");
   ap_second_follows: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ready && !last_ff) |=> valid_ff)
      else $error("gap after first byte of a pair");

endmodule

>>> src/command_frame_builder_crc16.sv
// Top level: command frame builder with CRC-16/CCITT-FALSE trailer.
// The first byte of an accepted item passes the queue slot and then the output byte register.
// Up to one body item per cycle while the queue has room and the output is taken; start
// and end items are each emitted as two bytes through the single output byte register.
// A queue of QUEUE_DEPTH entries between the CRC front end and the byte emitter.
// Synchronous reset empties the queue and output and loads the CRC with 0xFFFF.
`timescale 1ns / 1ps
module command_frame_builder_crc16 #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic        clock,
   input logic        reset,
   cfb_req_if.sink    req_chan,
   cfb_rsp_if.source  rsp_chan
);
   import cfb_pkg::*;

   logic            q_full;
   logic            push;
   logic            pop;
   logic            head_valid;
   frame_entry_type push_entry;
   frame_entry_type head_entry;

   cfb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .in_op        (req_chan.op),
      .in_command   (req_chan.command),
      .in_body_byte (req_chan.body_byte),
      .q_full       (q_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   cfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   cfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_byte   (rsp_chan.out_byte),
      .out_last   (rsp_chan.last_of_run),
      .out_done   (rsp_chan.frame_done)
   );

endmodule

>>> tb/command_frame_builder_crc16_tb.sv
// Testbench: command frame builder, byte stream checked against a CRC-16/CCITT-FALSE predictor.
`timescale 1ns / 1ps
module command_frame_builder_crc16_tb;
   import cfb_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_done;
   } frame_byte_type;

   typedef struct packed {
      logic [1:0]     op;
      logic [15:0]    command;
      logic [7:0]     body_byte;
      logic           typed;
      frame_byte_type first;
      frame_byte_type second;
   } stim_row_type;

   logic clock;
   logic reset;

   cfb_req_if req_if ();
   cfb_rsp_if rsp_if ();

   command_frame_builder_crc16 i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   frame_byte_type frame_bytes_due[$];
   frame_byte_type model_bytes[2];
   frame_byte_type due_byte;
   stim_row_type   directed_rows[$];
   logic [15:0]    model_crc;
   int             error_count;
   int             items_sent;
   bit             no_idle;

   // bit-serial form of the MSB-first CRC update
   function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // updates the frame state, leaves the bytes in model_bytes, returns their count
   function automatic int frame_model_step(input logic [1:0] op, input logic [15:0] cmd,
                                           input logic [7:0] body);
      case (op)
         OP_START: begin
            model_crc      = crc_ccitt_byte(crc_ccitt_byte(CRC_INIT, cmd[7:0]), cmd[15:8]);
            model_bytes[0] = {cmd[7:0], 1'b0, 1'b0};
            model_bytes[1] = {cmd[15:8], 1'b1, 1'b0};
            return 2;
         end
         OP_BODY: begin
            model_crc      = crc_ccitt_byte(model_crc, body);
            model_bytes[0] = {body, 1'b1, 1'b0};
            return 1;
         end
         OP_END: begin
            model_bytes[0] = {model_crc[7:0], 1'b0, 1'b0};
            model_bytes[1] = {model_crc[15:8], 1'b1, 1'b1};
            return 2;
         end
         default: return 0;
      endcase
   endfunction

   function automatic stim_row_type stim(input logic [1:0] op, input logic [15:0] cmd,
                                         input logic [7:0] body, input logic typed,
                                         input frame_byte_type first,
                                         input frame_byte_type second);
      stim_row_type r;
      r.op        = op;
      r.command   = cmd;
      r.body_byte = body;
      r.typed     = typed;
      r.first     = first;
      r.second    = second;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input stim_row_type row);
      int n;
      while (!no_idle && $urandom_range(99) < 37) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.op        <= row.op;
      req_if.command   <= row.command;
      req_if.body_byte <= row.body_byte;
      do @(posedge clock); while (!req_if.ready);
      n = frame_model_step(row.op, row.command, row.body_byte);
      if (n > 0) frame_bytes_due.push_back(row.typed ? row.first : model_bytes[0]);
      if (n > 1) frame_bytes_due.push_back(row.typed ? row.second : model_bytes[1]);
      if (row.op != OP_NONE) items_sent++;
   endtask

   // hold the sender off until every byte owed has come out
   task automatic drain_frames();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (frame_bytes_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch("out_byte with nothing due", int'(rsp_if.out_byte), 0);
         end else begin
            due_byte = frame_bytes_due.pop_front();
            if (rsp_if.out_byte !== due_byte.out_byte)
               report_mismatch("out_byte", int'(rsp_if.out_byte), int'(due_byte.out_byte));
            if (rsp_if.last_of_run !== due_byte.last_of_run)
               report_mismatch("last_of_run", int'(rsp_if.last_of_run),
                               int'(due_byte.last_of_run));
            if (rsp_if.frame_done !== due_byte.frame_done)
               report_mismatch("frame_done", int'(rsp_if.frame_done),
                               int'(due_byte.frame_done));
         end
      end
   end

   initial begin
      int pick;
      int nbody;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.op        <= OP_NONE;
      req_if.command   <= 16'h0000;
      req_if.body_byte <= 8'h00;
      model_crc   = CRC_INIT;
      error_count = 0;
      items_sent  = 0;
      no_idle     = 1'b0;

      // typed rows give {byte, last_of_run, frame_done}
      directed_rows.push_back(stim(OP_END, 16'h0000, 8'h00, 1'b1,
                                   {8'hFF, 2'b00}, {8'hFF, 2'b11}));
      directed_rows.push_back(stim(OP_NONE, 16'hFFFF, 8'hFF, 1'b1, '0, '0));
      directed_rows.push_back(stim(OP_BODY, 16'h0000, 8'h00, 1'b1, {8'h00, 2'b10}, '0));
      directed_rows.push_back(stim(OP_END, 16'h0000, 8'h00, 1'b0, '0, '0));
      directed_rows.push_back(stim(OP_END, 16'hFFFF, 8'hFF, 1'b0, '0, '0));
      directed_rows.push_back(stim(OP_BODY, 16'hFFFF, 8'hFF, 1'b1, {8'hFF, 2'b10}, '0));
      directed_rows.push_back(stim(OP_END, 16'h0000, 8'h00, 1'b0, '0, '0));
      directed_rows.push_back(stim(OP_START, 16'h0000, 8'hFF, 1'b1,
                                   {8'h00, 2'b00}, {8'h00, 2'b10}));
      directed_rows.push_back(stim(OP_END, 16'h0000, 8'h00, 1'b0, '0, '0));
      directed_rows.push_back(stim(OP_START, 16'hFFFF, 8'h00, 1'b1,
                                   {8'hFF, 2'b00}, {8'hFF, 2'b10}));
      directed_rows.push_back(stim(OP_BODY, 16'h0000, 8'hA5, 1'b1, {8'hA5, 2'b10}, '0));
      directed_rows.push_back(stim(OP_END, 16'h0000, 8'h00, 1'b0, '0, '0));
      // "123456789" gives the well-known check value 0x29B1
      directed_rows.push_back(stim(OP_START, 16'h3231, 8'h00, 1'b1,
                                   {8'h31, 2'b00}, {8'h32, 2'b10}));
      for (int d = 8'h33; d <= 8'h39; d++)
         directed_rows.push_back(stim(OP_BODY, 16'h0000, d[7:0], 1'b1, {d[7:0], 2'b10}, '0));
      directed_rows.push_back(stim(OP_END, 16'h0000, 8'h00, 1'b1,
                                   {8'hB1, 2'b00}, {8'h29, 2'b11}));
      directed_rows.push_back(stim(OP_NONE, 16'h5A5A, 8'h3C, 1'b1, '0, '0));
      directed_rows.push_back(stim(OP_START, 16'h8001, 8'h00, 1'b0, '0, '0));
      directed_rows.push_back(stim(OP_BODY, 16'h0000, 8'h80, 1'b0, '0, '0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      drain_frames();

      while (items_sent < 1140) begin
         no_idle = (items_sent >= 500 && items_sent < 700);
         pick    = $urandom_range(99);
         if (pick < 84) begin
            send_item(stim(OP_START, 16'($urandom), 8'($urandom), 1'b0, '0, '0));
            nbody = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            repeat (nbody) send_item(stim(OP_BODY, 16'($urandom), 8'($urandom), 1'b0, '0, '0));
            // a few frames are cut short and run into the next start
            if (pick < 76) send_item(stim(OP_END, 16'($urandom), 8'($urandom), 1'b0, '0, '0));
         end else begin
            send_item(stim(2'($urandom_range(3)), 16'($urandom), 8'($urandom), 1'b0, '0, '0));
         end
         if ($urandom_range(59) == 0) drain_frames();
      end

      drain_frames();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
